[design/nnd_pkg.sv]
// Shared types, constants and helpers for the nearest-neighbor downscaler.
// Used by every module of the block except nnd_queue, and by the stream interfaces.
package nnd_pkg;

    localparam int DIM_W    = 16;
    localparam int PROD_W   = 2 * DIM_W;
    localparam int NUM_CHAN = 4;
    localparam int CHAN_W   = 8;
    localparam int CNT_W    = 3;
    localparam int MAX_DIM  = 65535;
    localparam int LANES_DEF = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_W-1:0] MAX_SIZE_RST = DIM_W'(4096);
    localparam logic [CNT_W-1:0] CHAN_CNT_RST = CNT_W'(4);

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_MAX_SIZE   = 2'd2,
        REG_CHAN_COUNT = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_MUL,
        ST_DIV_OW,
        ST_DIV_OH,
        ST_DIV_CS,
        ST_DIV_RS,
        ST_READY
    } t_setup_state;

    // Frame geometry worked out once per configuration.
    typedef struct packed {
        logic             resize;
        logic [DIM_W-1:0] src_w;
        logic [DIM_W-1:0] src_h;
        logic [DIM_W-1:0] out_w;
        logic [DIM_W-1:0] out_h;
        logic [DIM_W-1:0] col_q;
        logic [DIM_W-1:0] col_r;
        logic [DIM_W-1:0] row_q;
        logic [DIM_W-1:0] row_r;
    } t_geom;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

[design/nnd_in_if.sv]
// Source pixel stream interface: valid/ready handshake with four channel bytes.
// Depends on nnd_pkg for the channel width.
interface nnd_in_if;
    logic                          valid;
    logic                          ready;
    logic [nnd_pkg::CHAN_W-1:0]    in_chan0;
    logic [nnd_pkg::CHAN_W-1:0]    in_chan1;
    logic [nnd_pkg::CHAN_W-1:0]    in_chan2;
    logic [nnd_pkg::CHAN_W-1:0]    in_chan3;

    modport source (output valid, in_chan0, in_chan1, in_chan2, in_chan3, input ready);
    modport sink   (input valid, in_chan0, in_chan1, in_chan2, in_chan3, output ready);
endinterface

[design/nnd_out_if.sv]
// Result pixel stream interface: valid/ready handshake, channel bytes and row/frame marks.
// Depends on nnd_pkg for the channel width.
interface nnd_out_if;
    logic                          valid;
    logic                          ready;
    logic [nnd_pkg::CHAN_W-1:0]    out_chan0;
    logic [nnd_pkg::CHAN_W-1:0]    out_chan1;
    logic [nnd_pkg::CHAN_W-1:0]    out_chan2;
    logic [nnd_pkg::CHAN_W-1:0]    out_chan3;
    logic                          row_end;
    logic                          frame_end;

    modport source (output valid, out_chan0, out_chan1, out_chan2, out_chan3, row_end,
                    frame_end, input ready);
    modport sink   (input valid, out_chan0, out_chan1, out_chan2, out_chan3, row_end,
                    frame_end, output ready);
endinterface

[design/nearest_neighbor_downscaler_core.sv]
// Top level of the nearest-neighbor downscaler: configuration registers, setup, queue.
// Depends on nnd_pkg, nnd_in_if, nnd_out_if, nnd_setup, nnd_front and nnd_queue.
//
//   Port        Dir  Handshake          Carries
//   i_pix       in   valid/ready        one source pixel, four channel bytes
//   o_pix       out  valid/ready        one kept pixel, channel bytes, row/frame end
//   i_cfg_*     in   write enable only  register index and 16-bit value
//
// One pixel is taken per cycle once the frame geometry is ready and while the queue is not full.
// After reset and after any write to a size register the setup runs a multiply and four
// 32-step divisions on a shared divider, with the input held off.
// Output back-pressure fills a four-entry queue; when it is full the input is stalled.
// Reset is synchronous and active low; it restores the register defaults.
module nearest_neighbor_downscaler_core #(
    parameter int LANES = nnd_pkg::LANES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    nnd_in_if.sink                      i_pix,
    nnd_out_if.source                   o_pix,
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_addr,
    input  logic [nnd_pkg::DIM_W-1:0]   i_cfg_wdata
);
    localparam int DW     = nnd_pkg::DIM_W;
    localparam int CH     = nnd_pkg::CHAN_W;
    localparam int BEAT_W = LANES * CH + 2;

    logic [DW-1:0]                r_src_width, r_src_height, r_max_size;
    logic [nnd_pkg::CNT_W-1:0]    r_chan_cnt;
    logic                         dim_wr;
    logic                         geom_ok;
    nnd_pkg::t_geom               geom;
    logic [nnd_pkg::NUM_CHAN-1:0][CH-1:0] in_chans;
    logic [nnd_pkg::NUM_CHAN-1:0][CH-1:0] out_lanes;
    logic                         q_full, q_valid, push;
    logic [BEAT_W-1:0]            push_data, q_data;

    always_comb begin
        dim_wr = i_cfg_wr_en && (i_cfg_addr inside {nnd_pkg::REG_SRC_WIDTH,
                 nnd_pkg::REG_SRC_HEIGHT, nnd_pkg::REG_MAX_SIZE});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DW'(1);
            r_src_height <= DW'(1);
            r_max_size   <= nnd_pkg::MAX_SIZE_RST;
            r_chan_cnt   <= nnd_pkg::CHAN_CNT_RST;
        end else if (i_cfg_wr_en) begin
            case (nnd_pkg::t_cfg_reg'(i_cfg_addr))
                nnd_pkg::REG_SRC_WIDTH:  r_src_width  <= i_cfg_wdata;
                nnd_pkg::REG_SRC_HEIGHT: r_src_height <= i_cfg_wdata;
                nnd_pkg::REG_MAX_SIZE:   r_max_size   <= i_cfg_wdata;
                nnd_pkg::REG_CHAN_COUNT: r_chan_cnt   <= i_cfg_wdata[nnd_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    nnd_setup u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (dim_wr),
        .i_w       (nnd_pkg::eff_dim(r_src_width)),
        .i_h       (nnd_pkg::eff_dim(r_src_height)),
        .i_m       (nnd_pkg::eff_dim(r_max_size)),
        .o_ready   (geom_ok),
        .o_geom    (geom)
    );

    assign in_chans = {i_pix.in_chan3, i_pix.in_chan2, i_pix.in_chan1, i_pix.in_chan0};

    nnd_front #(
        .LANES (LANES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (dim_wr),
        .i_geom_ok   (geom_ok),
        .i_geom      (geom),
        .i_chan_cnt  (r_chan_cnt),
        .i_valid     (i_pix.valid),
        .i_chans     (in_chans),
        .o_ready     (i_pix.ready),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    nnd_queue #(
        .WIDTH (BEAT_W),
        .DEPTH (nnd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_ready (o_pix.ready),
        .o_data  (q_data)
    );

    for (genvar k = 0; k < nnd_pkg::NUM_CHAN; k++) begin : g_lane
        if (k < LANES) begin : g_live
            assign out_lanes[k] = q_data[k*CH +: CH];
        end else begin : g_zero
            assign out_lanes[k] = '0;
        end
    end

    assign o_pix.valid     = q_valid;
    assign o_pix.out_chan0 = out_lanes[0];
    assign o_pix.out_chan1 = out_lanes[1];
    assign o_pix.out_chan2 = out_lanes[2];
    assign o_pix.out_chan3 = out_lanes[3];
    assign o_pix.row_end   = q_data[LANES*CH];
    assign o_pix.frame_end = q_data[LANES*CH+1];

`ifndef SYNTHESIS
    a_accept_needs_geom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |-> geom_ok)
        else $error("pixel transfer accepted before frame geometry was ready");

    a_frame_end_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.frame_end) |-> o_pix.row_end)
        else $error("frame end marked on a pixel that does not end a row");

    a_size_write_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wr_en && (i_cfg_addr == nnd_pkg::REG_SRC_WIDTH ||
         i_cfg_addr == nnd_pkg::REG_SRC_HEIGHT || i_cfg_addr == nnd_pkg::REG_MAX_SIZE))
        |=> !i_pix.ready)
        else $error("input ready right after a size register write");
`endif
endmodule

[design/nnd_div.sv]
// Restoring divider, one quotient bit per cycle, for the frame geometry setup.
// Depends on nnd_pkg for operand widths.
module nnd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_abort,
    input  logic                        i_start,
    input  logic [nnd_pkg::PROD_W-1:0]  i_dividend,
    input  logic [nnd_pkg::DIM_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [nnd_pkg::PROD_W-1:0]  o_quo,
    output logic [nnd_pkg::DIM_W-1:0]   o_rem
);
    localparam int DW = nnd_pkg::DIM_W;
    localparam int PW = nnd_pkg::PROD_W;
    localparam int CW = $clog2(PW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [PW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_dvs, n_dvs;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
        trial = {r_rem, r_quo[PW-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = trial >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_abort) begin
            n_busy = 1'b0;
        end else if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(PW);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
            n_quo = {r_quo[PW-2:0], ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

[design/nnd_setup.sv]
// Works out output size and per-step source increments for the current configuration.
// Depends on nnd_pkg and on nnd_div, which it shares across four divisions.
module nnd_setup (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_restart,
    input  logic [nnd_pkg::DIM_W-1:0]  i_w,
    input  logic [nnd_pkg::DIM_W-1:0]  i_h,
    input  logic [nnd_pkg::DIM_W-1:0]  i_m,
    output logic                       o_ready,
    output nnd_pkg::t_geom             o_geom
);
    localparam int DW = nnd_pkg::DIM_W;
    localparam int PW = nnd_pkg::PROD_W;

    nnd_pkg::t_setup_state r_state, n_state;
    logic                  r_kick, n_kick;
    logic [PW-1:0]         r_prod_w;
    logic [PW-1:0]         r_prod_h;
    logic [DW-1:0]         r_big;
    nnd_pkg::t_geom        r_geom;

    logic                  div_done;
    logic [PW-1:0]         div_quo;
    logic [DW-1:0]         div_rem;
    logic [PW-1:0]         dividend;
    logic [DW-1:0]         divisor;
    logic [DW-1:0]         quo_lo;

    always_comb begin
        n_state = r_state;
        case (r_state)
            nnd_pkg::ST_MUL: begin
                n_state = nnd_pkg::ST_DIV_OW;
            end
            nnd_pkg::ST_DIV_OW: begin
                if (div_done) begin
                    n_state = nnd_pkg::ST_DIV_OH;
                end
            end
            nnd_pkg::ST_DIV_OH: begin
                if (div_done) begin
                    n_state = nnd_pkg::ST_DIV_CS;
                end
            end
            nnd_pkg::ST_DIV_CS: begin
                if (div_done) begin
                    n_state = nnd_pkg::ST_DIV_RS;
                end
            end
            nnd_pkg::ST_DIV_RS: begin
                if (div_done) begin
                    n_state = nnd_pkg::ST_READY;
                end
            end
            nnd_pkg::ST_READY: begin
                n_state = nnd_pkg::ST_READY;
            end
            default: begin
                n_state = nnd_pkg::ST_MUL;
            end
        endcase
        if (i_restart) begin
            n_state = nnd_pkg::ST_MUL;
        end
        n_kick = (n_state != r_state) && (n_state != nnd_pkg::ST_MUL) &&
                 (n_state != nnd_pkg::ST_READY);
    end

    always_comb begin
        dividend = '0;
        divisor  = DW'(1);
        o_ready  = 1'b0;
        case (r_state)
            nnd_pkg::ST_DIV_OW: begin
                dividend = r_prod_w;
                divisor  = r_big;
            end
            nnd_pkg::ST_DIV_OH: begin
                dividend = r_prod_h;
                divisor  = r_big;
            end
            nnd_pkg::ST_DIV_CS: begin
                dividend = PW'(r_geom.src_w);
                divisor  = r_geom.out_w;
            end
            nnd_pkg::ST_DIV_RS: begin
                dividend = PW'(r_geom.src_h);
                divisor  = r_geom.out_h;
            end
            nnd_pkg::ST_READY: begin
                o_ready = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    nnd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_abort    (i_restart),
        .i_start    (r_kick),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign quo_lo = div_quo[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nnd_pkg::ST_MUL;
            r_kick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= n_kick;
        end
        case (r_state)
            nnd_pkg::ST_MUL: begin
                r_prod_w      <= PW'(i_w) * PW'(i_m);
                r_prod_h      <= PW'(i_h) * PW'(i_m);
                r_big         <= (i_w > i_h) ? i_w : i_h;
                r_geom.src_w  <= i_w;
                r_geom.src_h  <= i_h;
                r_geom.resize <= (i_w > i_m) || (i_h > i_m);
            end
            nnd_pkg::ST_DIV_OW: begin
                if (div_done) begin
                    if (!r_geom.resize) begin
                        r_geom.out_w <= r_geom.src_w;
                    end else if (quo_lo == '0) begin
                        r_geom.out_w <= DW'(1);
                    end else begin
                        r_geom.out_w <= quo_lo;
                    end
                end
            end
            nnd_pkg::ST_DIV_OH: begin
                if (div_done) begin
                    if (!r_geom.resize) begin
                        r_geom.out_h <= r_geom.src_h;
                    end else if (quo_lo == '0) begin
                        r_geom.out_h <= DW'(1);
                    end else begin
                        r_geom.out_h <= quo_lo;
                    end
                end
            end
            nnd_pkg::ST_DIV_CS: begin
                if (div_done) begin
                    r_geom.col_q <= quo_lo;
                    r_geom.col_r <= div_rem;
                end
            end
            nnd_pkg::ST_DIV_RS: begin
                if (div_done) begin
                    r_geom.row_q <= quo_lo;
                    r_geom.row_r <= div_rem;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_geom = r_geom;
endmodule

[design/nnd_front.sv]
// Input side: tracks source and output positions, picks the pixels to keep and marks ends.
// Depends on nnd_pkg for the geometry struct and widths.
module nnd_front #(
    parameter int LANES = nnd_pkg::LANES_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_clear,
    input  logic                                            i_geom_ok,
    input  nnd_pkg::t_geom                                  i_geom,
    input  logic [nnd_pkg::CNT_W-1:0]                       i_chan_cnt,
    input  logic                                            i_valid,
    input  logic [nnd_pkg::NUM_CHAN-1:0][nnd_pkg::CHAN_W-1:0] i_chans,
    output logic                                            o_ready,
    input  logic                                            i_q_full,
    output logic                                            o_push,
    output logic [LANES*nnd_pkg::CHAN_W+1:0]                o_push_data
);
    localparam int DW = nnd_pkg::DIM_W;
    localparam int CH = nnd_pkg::CHAN_W;
    localparam int LW = LANES * CH;

    logic [DW-1:0] r_col, r_row, r_ocol, r_orow, r_wcol, r_wrow, r_crem, r_rrem;
    logic [DW-1:0] n_wcol, n_wrow, n_crem, n_rrem;
    logic [DW:0]   csum, rsum, cdiff, rdiff;
    logic          cwrap, rwrap;
    logic          fire, hit, sel, re, fe;
    logic          src_last_col, src_last_row, o_last_col, o_last_row;
    logic [LW-1:0] lanes;

    assign o_ready = i_geom_ok && !i_q_full && !i_clear;
    assign fire    = i_valid && o_ready;

    always_comb begin
        src_last_col = r_col == i_geom.src_w - DW'(1);
        src_last_row = r_row == i_geom.src_h - DW'(1);
        o_last_col   = r_ocol == i_geom.out_w - DW'(1);
        o_last_row   = r_orow == i_geom.out_h - DW'(1);
        hit = (r_orow < i_geom.out_h) && (r_row == r_wrow) && (r_col == r_wcol);
        sel = i_geom.resize ? hit : 1'b1;
        re  = i_geom.resize ? o_last_col : src_last_col;
        fe  = re && (i_geom.resize ? o_last_row : src_last_row);

        csum   = {1'b0, r_crem} + {1'b0, i_geom.col_r};
        cdiff  = csum - {1'b0, i_geom.out_w};
        cwrap  = csum >= {1'b0, i_geom.out_w};
        n_crem = cwrap ? cdiff[DW-1:0] : csum[DW-1:0];
        n_wcol = r_wcol + i_geom.col_q + DW'(cwrap);

        rsum   = {1'b0, r_rrem} + {1'b0, i_geom.row_r};
        rdiff  = rsum - {1'b0, i_geom.out_h};
        rwrap  = rsum >= {1'b0, i_geom.out_h};
        n_rrem = rwrap ? rdiff[DW-1:0] : rsum[DW-1:0];
        n_wrow = r_wrow + i_geom.row_q + DW'(rwrap);

        for (int k = 0; k < LANES; k++) begin
            lanes[k*CH +: CH] = (i_chan_cnt > nnd_pkg::CNT_W'(k)) ? i_chans[k] : '0;
        end
    end

    assign o_push      = fire && sel;
    assign o_push_data = {fe, re, lanes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_wcol <= '0;
            r_wrow <= '0;
            r_crem <= '0;
            r_rrem <= '0;
        end else if (fire) begin
            if (src_last_col && src_last_row) begin
                r_col  <= '0;
                r_row  <= '0;
                r_ocol <= '0;
                r_orow <= '0;
                r_wcol <= '0;
                r_wrow <= '0;
                r_crem <= '0;
                r_rrem <= '0;
            end else begin
                if (i_geom.resize && hit) begin
                    if (o_last_col) begin
                        r_ocol <= '0;
                        r_wcol <= '0;
                        r_crem <= '0;
                        r_orow <= r_orow + DW'(1);
                        r_wrow <= n_wrow;
                        r_rrem <= n_rrem;
                    end else begin
                        r_ocol <= r_ocol + DW'(1);
                        r_wcol <= n_wcol;
                        r_crem <= n_crem;
                    end
                end
                if (src_last_col) begin
                    r_col <= '0;
                    r_row <= r_row + DW'(1);
                end else begin
                    r_col <= r_col + DW'(1);
                end
            end
        end
    end
endmodule

[design/nnd_queue.sv]
// Short first-in first-out queue between the classifier and the output port.
// Standalone; the head entry drives the output directly from its register.
module nnd_queue #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             push, pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rptr];
    assign push    = i_push && !o_full;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule
